// ===== src/hng_pkg.sv =====
// hng_pkg: shared types and constants of the heightmap normal generator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package hng_pkg;

	localparam int HEIGHT_W = 18;
	localparam int ROW_W    = 12;
	localparam int CFG_W    = 16;
	localparam int CIDX_W   = 2;
	localparam int ROOT_W   = 27;
	localparam int RAD_W    = 54;
	localparam int DIV_W    = 42;
	localparam int QUO_W    = 16;
	localparam int NORM_W   = 16;

	localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_ROWS  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_HEIGHT_GAIN = 2'd2;

	localparam logic [10:0] WIDTH_RESET = 11'd1024;
	localparam logic [12:0] ROWS_RESET  = 13'd1024;
	localparam logic [15:0] GAIN_RESET  = 16'd10240;
	localparam logic [12:0] ROWS_LIMIT  = 13'd4096;
	localparam logic [QUO_W-1:0] ONE_Q14 = 16'd16384;

	// result kinds: pixel above, last-row pixel to the left, last pixel itself
	typedef enum logic [1:0] {
		RES_ABOVE = 2'd0,
		RES_LEFT  = 2'd1,
		RES_SELF  = 2'd2
	} hng_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_WR,
		ST_RD,
		ST_SQX,
		ST_SQZ,
		ST_SUM,
		ST_SQRT,
		ST_DSET,
		ST_DIV,
		ST_OUT
	} hng_state_t;

endpackage
`default_nettype wire

// ===== src/heightmap_normal_generator.sv =====
// heightmap_normal_generator: heights from rgb pixels, line buffer memory and
// central-difference unit normals; depends on hng_pkg
`timescale 1ns / 1ps
`default_nettype none
// One pixel is taken at a time. It passes through the height multiply and the
// line buffer write, then each of its 0 to 3 results goes through four reads of
// the single read port of the line buffer, the squares, the bit-pair square
// root, the 16-step divider and an output state that waits on out_ready. A
// pixel with no result returns to idle straight after the line buffer write.
// The line buffer holds three rows of MAX_WIDTH heights and is not cleared.
// A write to any of the three defined configuration indices restarts the image at row 0, column 0.
module heightmap_normal_generator #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [hng_pkg::CIDX_W-1:0]        cfg_index,
	input  wire logic [hng_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        red,
	input  wire logic [7:0]                        green,
	input  wire logic [7:0]                        blue,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [$clog2(MAX_WIDTH)-1:0]           pixel_column,
	output logic [hng_pkg::ROW_W-1:0]              pixel_row,
	output logic [hng_pkg::HEIGHT_W-1:0]           vertex_height,
	output logic signed [hng_pkg::NORM_W-1:0]      normal_x,
	output logic [hng_pkg::NORM_W-2:0]             normal_y,
	output logic signed [hng_pkg::NORM_W-1:0]      normal_z,
	output logic                                   last_of_run
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = $clog2(3 * MAX_WIDTH);
	localparam int HW = hng_pkg::HEIGHT_W;

	hng_pkg::hng_state_t state_q, state_d;

	logic [10:0] width_q;
	logic [12:0] rows_q;
	logic [15:0] gain_q;

	logic [CW-1:0] x_q;
	logic [hng_pkg::ROW_W-1:0] z_q;
	logic [1:0] bank_q;
	logic [2:0] res_q;
	hng_pkg::hng_res_t cur_q;

	logic [7:0] red_q, green_q, blue_q;
	logic [15:0] rg_q;
	logic [23:0] rgb_q;
	logic [HW-1:0] h_q;

	logic [HW-1:0] mem [0:3*MAX_WIDTH-1];
	logic [HW-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;

	logic [2:0] slot_q;
	logic cap_v_s1, cap_mem_s1;
	logic [1:0] cap_slot_s1;
	logic [HW-1:0] cap_val_s1;
	logic [HW-1:0] opnd_q [0:3];

	logic [35:0] dx2_q, dz2_q;
	logic [hng_pkg::RAD_W-1:0] v_q, r_q, b_q;
	logic [hng_pkg::DIV_W-1:0] d_q, remx_q, remy_q, remz_q;
	logic [hng_pkg::QUO_W-1:0] qx_q, qy_q, qz_q;
	logic [3:0] cnt_q;
	logic sx_q, sz_q;

	// clamped geometry
	logic [CW:0] w_used;
	logic [12:0] rows_used;
	always_comb begin
		if (width_q < 11'd2) begin
			w_used = (CW+1)'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_used = (CW+1)'(MAX_WIDTH);
		end else begin
			w_used = (CW+1)'(width_q);
		end
		if (rows_q < 13'd2) begin
			rows_used = 13'd2;
		end else if (rows_q > hng_pkg::ROWS_LIMIT) begin
			rows_used = hng_pkg::ROWS_LIMIT;
		end else begin
			rows_used = rows_q;
		end
	end

	logic [CW:0] x_ext, x_inc;
	logic last_row, last_col;
	logic [1:0] bank_prev, bank_next;
	assign x_ext     = (CW+1)'(x_q);
	assign x_inc     = x_ext + 1'b1;
	assign last_row  = (13'(z_q) + 13'd1) == rows_used;
	assign last_col  = x_inc == w_used;
	assign bank_prev = (bank_q == 2'd0) ? 2'd2 : bank_q - 2'd1;
	assign bank_next = (bank_q == 2'd2) ? 2'd0 : bank_q + 2'd1;

	// operand slot decode: self, left, right, down
	logic slot_mem, slot_h;
	logic [1:0] slot_bank;
	logic [CW-1:0] slot_col;
	always_comb begin
		slot_mem  = 1'b0;
		slot_h    = 1'b0;
		slot_bank = bank_q;
		slot_col  = x_q;
		case (cur_q)
			hng_pkg::RES_ABOVE: begin
				slot_bank = bank_prev;
				case (slot_q[1:0])
					2'd0: slot_mem = 1'b1;
					2'd1: begin
						slot_mem = x_q != '0;
						slot_col = x_q - 1'b1;
					end
					2'd2: begin
						slot_mem = x_inc < w_used;
						slot_col = x_inc[CW-1:0];
					end
					default: begin
						slot_mem  = z_q >= hng_pkg::ROW_W'(2);
						slot_bank = bank_next;
					end
				endcase
			end
			hng_pkg::RES_LEFT: begin
				case (slot_q[1:0])
					2'd0: begin
						slot_mem = 1'b1;
						slot_col = x_q - 1'b1;
					end
					2'd1: begin
						slot_mem = x_q >= CW'(2);
						slot_col = x_q - CW'(2);
					end
					2'd2: slot_h = 1'b1;
					default: begin
						slot_mem  = 1'b1;
						slot_bank = bank_prev;
						slot_col  = x_q - 1'b1;
					end
				endcase
			end
			default: begin
				case (slot_q[1:0])
					2'd0: slot_h = 1'b1;
					2'd1: begin
						slot_mem = 1'b1;
						slot_col = x_q - 1'b1;
					end
					2'd2: slot_mem = 1'b0;
					default: begin
						slot_mem  = 1'b1;
						slot_bank = bank_prev;
					end
				endcase
			end
		endcase
	end

	assign raddr = AW'(slot_bank) * AW'(MAX_WIDTH) + AW'(slot_col);
	assign waddr = AW'(bank_q) * AW'(MAX_WIDTH) + AW'(x_q);

	// line buffer
	always_ff @(posedge clk) begin
		if (state_q == hng_pkg::ST_WR) begin
			mem[waddr] <= h_q;
		end
		if (state_q == hng_pkg::ST_RD && slot_q < 3'd4 && slot_mem) begin
			rdata_q <= mem[raddr];
		end
	end

	// pending results after the current one
	logic more;
	hng_pkg::hng_res_t next_res;
	always_comb begin
		more     = 1'b0;
		next_res = hng_pkg::RES_SELF;
		if (cur_q == hng_pkg::RES_ABOVE && res_q[1]) begin
			more     = 1'b1;
			next_res = hng_pkg::RES_LEFT;
		end else if (cur_q != hng_pkg::RES_SELF && res_q[2]) begin
			more = 1'b1;
		end
	end

	logic advance;
	assign advance = (state_q == hng_pkg::ST_WR && res_q == 3'b000) ||
		(state_q == hng_pkg::ST_OUT && out_ready && !more);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hng_pkg::ST_IDLE: if (in_valid) state_d = hng_pkg::ST_MUL1;
			hng_pkg::ST_MUL1: state_d = hng_pkg::ST_MUL2;
			hng_pkg::ST_MUL2: state_d = hng_pkg::ST_MUL3;
			hng_pkg::ST_MUL3: state_d = hng_pkg::ST_WR;
			hng_pkg::ST_WR: begin
				state_d = (res_q == 3'b000) ? hng_pkg::ST_IDLE : hng_pkg::ST_RD;
			end
			hng_pkg::ST_RD: if (slot_q == 3'd4) state_d = hng_pkg::ST_SQX;
			hng_pkg::ST_SQX: state_d = hng_pkg::ST_SQZ;
			hng_pkg::ST_SQZ: state_d = hng_pkg::ST_SUM;
			hng_pkg::ST_SUM: state_d = hng_pkg::ST_SQRT;
			hng_pkg::ST_SQRT: if (b_q[0]) state_d = hng_pkg::ST_DSET;
			hng_pkg::ST_DSET: state_d = hng_pkg::ST_DIV;
			hng_pkg::ST_DIV: if (cnt_q == 4'd15) state_d = hng_pkg::ST_OUT;
			hng_pkg::ST_OUT: begin
				if (out_ready) state_d = more ? hng_pkg::ST_RD : hng_pkg::ST_IDLE;
			end
			default: state_d = hng_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			hng_pkg::ST_IDLE: in_ready = 1'b1;
			hng_pkg::ST_OUT:  out_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hng_pkg::ST_IDLE;
			width_q  <= hng_pkg::WIDTH_RESET;
			rows_q   <= hng_pkg::ROWS_RESET;
			gain_q   <= hng_pkg::GAIN_RESET;
			x_q      <= '0;
			z_q      <= '0;
			bank_q   <= '0;
			res_q    <= '0;
			cur_q    <= hng_pkg::RES_ABOVE;
			slot_q   <= '0;
			cap_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hng_pkg::ST_IDLE && in_valid) begin
				res_q <= {last_row && last_col, last_row && x_q != '0, z_q != '0};
			end
			if (state_q == hng_pkg::ST_WR) begin
				cur_q <= res_q[0] ? hng_pkg::RES_ABOVE :
					res_q[1] ? hng_pkg::RES_LEFT : hng_pkg::RES_SELF;
			end
			if (state_q == hng_pkg::ST_OUT && out_ready && more) begin
				cur_q <= next_res;
			end
			if (state_q == hng_pkg::ST_RD) begin
				slot_q <= slot_q + 3'd1;
			end else begin
				slot_q <= '0;
			end
			cap_v_s1 <= state_q == hng_pkg::ST_RD && slot_q < 3'd4;
			if (advance) begin
				if (last_col) begin
					x_q <= '0;
					if (last_row) begin
						z_q    <= '0;
						bank_q <= '0;
					end else begin
						z_q    <= z_q + 1'b1;
						bank_q <= bank_next;
					end
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					hng_pkg::CFG_IMAGE_WIDTH: width_q <= cfg_data[10:0];
					hng_pkg::CFG_IMAGE_ROWS:  rows_q  <= cfg_data[12:0];
					hng_pkg::CFG_HEIGHT_GAIN: gain_q  <= cfg_data;
					default: ;
				endcase
				if (cfg_index == hng_pkg::CFG_IMAGE_WIDTH ||
					cfg_index == hng_pkg::CFG_IMAGE_ROWS ||
					cfg_index == hng_pkg::CFG_HEIGHT_GAIN) begin
					x_q    <= '0;
					z_q    <= '0;
					bank_q <= '0;
				end
			end
		end
	end

	// datapath
	logic signed [HW:0] dx, dz;
	logic [HW-1:0] hu;
	logic [hng_pkg::RAD_W-1:0] rb;
	logic [hng_pkg::ROOT_W-1:0] root;
	logic [40:0] hprod;
	assign hu    = (cur_q == hng_pkg::RES_ABOVE) ? h_q : '0;
	assign dx    = $signed({1'b0, opnd_q[1]}) - $signed({1'b0, opnd_q[2]});
	assign dz    = $signed({1'b0, opnd_q[3]}) - $signed({1'b0, hu});
	assign rb    = r_q + b_q;
	assign root  = r_q[hng_pkg::ROOT_W-1:0];
	assign hprod = 41'({1'b0, rgb_q} + 25'h800000) * 41'(gain_q);

	always_ff @(posedge clk) begin
		if (state_q == hng_pkg::ST_IDLE && in_valid) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
		rg_q  <= red_q * green_q;
		rgb_q <= 24'(rg_q * 24'(blue_q));
		if (state_q == hng_pkg::ST_MUL3) begin
			h_q <= hprod[40:23];
		end
		if (state_q == hng_pkg::ST_RD && slot_q < 3'd4) begin
			cap_slot_s1 <= slot_q[1:0];
			cap_mem_s1  <= slot_mem;
			cap_val_s1  <= slot_h ? h_q : '0;
		end
		if (cap_v_s1) begin
			opnd_q[cap_slot_s1] <= cap_mem_s1 ? rdata_q : cap_val_s1;
		end
		dx2_q <= 36'(dx * dx);
		dz2_q <= 36'(dz * dz);
		case (state_q)
			hng_pkg::ST_SUM: begin
				v_q <= hng_pkg::RAD_W'({(37'(dx2_q) + 37'(dz2_q) + 37'd262144), 16'd0});
				r_q <= '0;
				b_q <= hng_pkg::RAD_W'(1) << 52;
			end
			hng_pkg::ST_SQRT: begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
			end
			hng_pkg::ST_DSET: begin
				sx_q   <= dx < 0;
				sz_q   <= dz < 0;
				remx_q <= {2'd0, (dx < 0) ? HW'(-dx) : HW'(dx), 22'd0} +
					hng_pkg::DIV_W'(root >> 1);
				remy_q <= hng_pkg::DIV_W'(512) * hng_pkg::DIV_W'(4194304) +
					hng_pkg::DIV_W'(root >> 1);
				remz_q <= {2'd0, (dz < 0) ? HW'(-dz) : HW'(dz), 22'd0} +
					hng_pkg::DIV_W'(root >> 1);
				d_q    <= hng_pkg::DIV_W'(root) << 15;
				qx_q   <= '0;
				qy_q   <= '0;
				qz_q   <= '0;
				cnt_q  <= '0;
			end
			hng_pkg::ST_DIV: begin
				if (remx_q >= d_q) begin
					remx_q <= remx_q - d_q;
					qx_q   <= {qx_q[14:0], 1'b1};
				end else begin
					qx_q <= {qx_q[14:0], 1'b0};
				end
				if (remy_q >= d_q) begin
					remy_q <= remy_q - d_q;
					qy_q   <= {qy_q[14:0], 1'b1};
				end else begin
					qy_q <= {qy_q[14:0], 1'b0};
				end
				if (remz_q >= d_q) begin
					remz_q <= remz_q - d_q;
					qz_q   <= {qz_q[14:0], 1'b1};
				end else begin
					qz_q <= {qz_q[14:0], 1'b0};
				end
				d_q   <= d_q >> 1;
				cnt_q <= cnt_q + 4'd1;
			end
			default: ;
		endcase
	end

	// result fields
	logic [hng_pkg::QUO_W-1:0] satx, saty, satz;
	assign satx = (qx_q > hng_pkg::ONE_Q14) ? hng_pkg::ONE_Q14 : qx_q;
	assign saty = (qy_q > hng_pkg::ONE_Q14) ? hng_pkg::ONE_Q14 : qy_q;
	assign satz = (qz_q > hng_pkg::ONE_Q14) ? hng_pkg::ONE_Q14 : qz_q;

	always_comb begin
		pixel_column = x_q;
		pixel_row    = z_q;
		case (cur_q)
			hng_pkg::RES_ABOVE: pixel_row = z_q - 1'b1;
			hng_pkg::RES_LEFT:  pixel_column = x_q - 1'b1;
			default: begin
				pixel_column = x_q;
				pixel_row    = z_q;
			end
		endcase
	end

	assign vertex_height = (cur_q == hng_pkg::RES_SELF) ? h_q : opnd_q[0];
	assign normal_x      = sx_q ? -$signed(satx) : $signed(satx);
	assign normal_y      = saty[14:0];
	assign normal_z      = sz_q ? -$signed(satz) : $signed(satz);
	assign last_of_run   = !more;

	// checks
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("result shown while accepting input");

	a_accept_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result right after input transfer");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_run |=> in_ready)
		else $error("no return to idle after last result");

	a_normal_y_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_y != '0)
		else $error("zero normal y component");

endmodule
`default_nettype wire
